### hdl/lom_pkg.sv
// Shared types and constants for the limit order matcher.
// Used by the interfaces, the front end, the engine and the top level.
`default_nettype none

package lom_pkg;

  localparam int BOOK_DEPTH = 32;
  localparam int IDX_W = $clog2(BOOK_DEPTH);
  localparam int CNT_W = $clog2(BOOK_DEPTH + 1);

  localparam logic [1:0] ACT_BUY    = 2'd0;
  localparam logic [1:0] ACT_SELL   = 2'd1;
  localparam logic [1:0] ACT_QUERY  = 2'd2;
  localparam logic [1:0] ACT_UNUSED = 2'd3;

  localparam logic [1:0] KIND_FILL   = 2'd0;
  localparam logic [1:0] KIND_REST   = 2'd1;
  localparam logic [1:0] KIND_QUERY  = 2'd2;
  localparam logic [1:0] KIND_REJECT = 2'd3;

  typedef struct packed {
    logic [1:0]  action;
    logic [7:0]  symbol;
    logic [19:0] quantity;
    logic [23:0] price;
    logic [7:0]  broker;
    logic [19:0] query_tag;
  } req_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [7:0]  buyer;
    logic [7:0]  seller;
    logic [7:0]  out_symbol;
    logic [19:0] out_quantity;
    logic [23:0] ask_price;
    logic [23:0] bid_price;
    logic [19:0] tag_echo;
    logic        last;
  } res_t;

  typedef struct packed {
    logic [7:0]  symbol;
    logic [7:0]  broker;
    logic [19:0] qty;
    logic [23:0] price;
  } entry_t;

endpackage

`default_nettype wire

### hdl/lom_if.sv
// Valid/ready channel interfaces for requests and results.
// Depends on lom_pkg.
`default_nettype none

interface lom_req_if;
  import lom_pkg::*;
  logic valid;
  logic ready;
  logic [1:0]  action;
  logic [7:0]  symbol;
  logic [19:0] quantity;
  logic [23:0] price;
  logic [7:0]  broker;
  logic [19:0] query_tag;
  modport source (output valid, action, symbol, quantity, price, broker, query_tag,
                  input ready);
  modport sink (input valid, action, symbol, quantity, price, broker, query_tag,
                output ready);
endinterface

interface lom_res_if;
  logic valid;
  logic ready;
  logic [1:0]  kind;
  logic [7:0]  buyer;
  logic [7:0]  seller;
  logic [7:0]  out_symbol;
  logic [19:0] out_quantity;
  logic [23:0] ask_price;
  logic [23:0] bid_price;
  logic [19:0] tag_echo;
  logic        last;
  modport source (output valid, kind, buyer, seller, out_symbol, out_quantity, ask_price,
                  bid_price, tag_echo, last, input ready);
  modport sink (input valid, kind, buyer, seller, out_symbol, out_quantity, ask_price,
                bid_price, tag_echo, last, output ready);
endinterface

`default_nettype wire

### hdl/lom_front.sv
// Front end: takes requests, drops no-op ones, queues the rest (4 deep).
// Depends on lom_pkg.
`default_nettype none

module lom_front (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic in_valid,
  output logic      in_ready,
  input  wire lom_pkg::req_t in_req,
  output logic      q_valid,
  input  wire logic q_ready,
  output lom_pkg::req_t q_req
);
  import lom_pkg::*;

  req_t       fifo [4];
  logic [1:0] wr_ptr;
  logic [1:0] rd_ptr;
  logic [2:0] fill;
  logic       keep;
  logic       push;
  logic       pop;

  // unused action and zero-quantity orders produce nothing
  assign keep = (in_req.action == ACT_QUERY) ||
                ((in_req.action != ACT_UNUSED) && (in_req.quantity != '0));
  assign in_ready = (fill != 3'd4);
  assign push = in_valid && in_ready && keep;
  assign q_valid = (fill != 3'd0);
  assign q_req = fifo[rd_ptr];
  assign pop = q_valid && q_ready;

  always_ff @(posedge clk) begin
    if (push) fifo[wr_ptr] <= in_req;
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + 2'd1;
      if (pop) rd_ptr <= rd_ptr + 2'd1;
      fill <= fill + {2'd0, push} - {2'd0, pop};
    end
  end
endmodule

`default_nettype wire

### hdl/lom_engine.sv
// Matching engine: scans the opposite book one entry per cycle, emits fills and
// query answers, compacts removed entries, rests or rejects leftovers. Depends on lom_pkg.
`default_nettype none

module lom_engine (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic q_valid,
  output logic      q_ready,
  input  wire lom_pkg::req_t q_req,
  output logic      out_valid,
  input  wire logic out_ready,
  output lom_pkg::res_t out_res
);
  import lom_pkg::*;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_SCAN  = 3'd1;
  localparam logic [2:0] S_MATCH = 3'd2;
  localparam logic [2:0] S_SHIFT = 3'd3;
  localparam logic [2:0] S_REST  = 3'd4;
  localparam logic [2:0] S_EMIT  = 3'd5;

  entry_t bids [BOOK_DEPTH];
  entry_t asks [BOOK_DEPTH];
  logic [CNT_W-1:0] bid_count;
  logic [CNT_W-1:0] ask_count;

  logic [2:0]       state;
  req_t             cur;
  logic [19:0]      rem;
  logic [CNT_W-1:0] idx;
  logic             found;
  logic [IDX_W-1:0] pos;
  logic [23:0]      bestp;
  entry_t           rd_ent;
  entry_t           hit;
  logic [2:0]       after_emit;
  logic             buy;
  logic [CNT_W-1:0] ocount;
  logic             cand;
  logic             better;
  logic [19:0]      take;
  logic             own_full;
  logic             out_free;

  assign buy = (cur.action == ACT_BUY);
  assign ocount = buy ? ask_count : bid_count;
  assign own_full = buy ? (bid_count == CNT_W'(BOOK_DEPTH)) :
                          (ask_count == CNT_W'(BOOK_DEPTH));
  assign q_ready = (state == S_IDLE) && !out_valid;
  assign take = (rem < hit.qty) ? rem : hit.qty;
  // output register may be reloaded only once its result is gone or leaving
  assign out_free = !out_valid || out_ready;

  always_comb begin
    rd_ent = (cur.action == ACT_SELL) ? bids[idx[IDX_W-1:0]] : asks[idx[IDX_W-1:0]];
    if (cur.action == ACT_QUERY) begin
      cand = 1'b1;
      better = rd_ent.price < bestp;
    end else if (buy) begin
      cand = rd_ent.price <= cur.price;
      better = rd_ent.price < bestp;
    end else begin
      cand = rd_ent.price >= cur.price;
      better = rd_ent.price > bestp;
    end
    cand = cand && (rd_ent.symbol == cur.symbol);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      bid_count <= '0;
      ask_count <= '0;
      out_valid <= 1'b0;
    end else begin
      if (out_valid && out_ready) out_valid <= 1'b0;
      case (state)
        S_IDLE: begin
          if (q_valid && q_ready) begin
            cur <= q_req;
            rem <= q_req.quantity;
            idx <= '0;
            found <= 1'b0;
            bestp <= '0;
            state <= S_SCAN;
          end
        end
        S_SCAN: begin
          if (idx == ((cur.action == ACT_SELL) ? bid_count : ask_count)) begin
            if (cur.action == ACT_QUERY) begin
              if (out_free) begin
                out_res <= '{kind: KIND_QUERY, buyer: '0, seller: '0,
                             out_symbol: cur.symbol, out_quantity: '0,
                             ask_price: found ? bestp : 24'd0, bid_price: '0,
                             tag_echo: cur.query_tag, last: 1'b1};
                after_emit <= S_IDLE;
                state <= S_EMIT;
              end
            end else if (found) begin
              hit <= buy ? asks[pos] : bids[pos];
              state <= S_MATCH;
            end else begin
              state <= S_REST;
            end
          end else begin
            if (cand && (!found || better)) begin
              found <= 1'b1;
              bestp <= rd_ent.price;
              pos <= idx[IDX_W-1:0];
            end
            idx <= idx + 1'b1;
          end
        end
        S_MATCH: begin
          if (out_free) begin
            out_res <= '{kind: KIND_FILL,
                         buyer: buy ? cur.broker : hit.broker,
                         seller: buy ? hit.broker : cur.broker,
                         out_symbol: cur.symbol, out_quantity: take,
                         ask_price: buy ? hit.price : cur.price,
                         bid_price: buy ? cur.price : hit.price,
                         tag_echo: '0, last: (take == rem)};
            rem <= rem - take;
            if (take == hit.qty) begin
              idx <= {1'b0, pos};
              after_emit <= S_SHIFT;
            end else begin
              if (buy) asks[pos].qty <= hit.qty - take;
              else bids[pos].qty <= hit.qty - take;
              after_emit <= (take == rem) ? S_IDLE : S_SCAN;
              idx <= '0;
            end
            found <= 1'b0;
            bestp <= '0;
            state <= S_EMIT;
          end
        end
        S_SHIFT: begin
          // close the gap one entry per cycle, then drop the count
          if (idx + 1'b1 >= ocount) begin
            if (buy) ask_count <= ask_count - 1'b1;
            else bid_count <= bid_count - 1'b1;
            idx <= '0;
            state <= (rem == '0) ? S_IDLE : S_SCAN;
          end else begin
            if (buy) asks[idx[IDX_W-1:0]] <= asks[IDX_W'(idx + 1'b1)];
            else bids[idx[IDX_W-1:0]] <= bids[IDX_W'(idx + 1'b1)];
            idx <= idx + 1'b1;
          end
        end
        S_REST: begin
          if (out_free) begin
            if (!own_full) begin
              if (buy) begin
                bids[bid_count[IDX_W-1:0]] <= '{cur.symbol, cur.broker, rem, cur.price};
                bid_count <= bid_count + 1'b1;
              end else begin
                asks[ask_count[IDX_W-1:0]] <= '{cur.symbol, cur.broker, rem, cur.price};
                ask_count <= ask_count + 1'b1;
              end
            end
            out_res <= '{kind: own_full ? KIND_REJECT : KIND_REST,
                         buyer: buy ? cur.broker : 8'd0,
                         seller: buy ? 8'd0 : cur.broker,
                         out_symbol: cur.symbol, out_quantity: rem,
                         ask_price: buy ? 24'd0 : cur.price,
                         bid_price: buy ? cur.price : 24'd0,
                         tag_echo: '0, last: 1'b1};
            after_emit <= S_IDLE;
            state <= S_EMIT;
          end
        end
        S_EMIT: begin
          if (out_free) begin
            out_valid <= 1'b1;
            state <= after_emit;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end
endmodule

`default_nettype wire

### hdl/limit_order_matcher.sv
// Top level of the limit order matcher: front queue plus matching engine.
// Depends on lom_pkg, lom_if, lom_front and lom_engine.
`default_nettype none

// Keeps a bid and an ask book of 32 entries each. An accepted request is
// loaded into the engine; each match pass then scans the opposite book one
// entry per cycle. A fill goes through a match and an emit state, and removing
// a consumed entry shifts each entry behind it down one place; a rest or
// reject goes through a rest and an emit state. A request enters the engine
// only after the previous result has left, and a stalled result holds the
// engine before it loads the next one. A 4-deep queue in front takes requests
// while the engine works; results leave through one output register.
module limit_order_matcher (
  input wire logic clk,
  input wire logic rst,
  lom_req_if.sink   req,
  lom_res_if.source res
);
  import lom_pkg::*;

  req_t in_req;
  req_t q_req;
  res_t out_res;
  logic q_valid;
  logic q_ready;

  assign in_req = '{req.action, req.symbol, req.quantity, req.price, req.broker,
                    req.query_tag};

  lom_front u_front (
    .clk, .rst, .in_valid(req.valid), .in_ready(req.ready), .in_req,
    .q_valid, .q_ready, .q_req
  );

  lom_engine u_engine (
    .clk, .rst, .q_valid, .q_ready, .q_req,
    .out_valid(res.valid), .out_ready(res.ready), .out_res
  );

  assign res.kind = out_res.kind;
  assign res.buyer = out_res.buyer;
  assign res.seller = out_res.seller;
  assign res.out_symbol = out_res.out_symbol;
  assign res.out_quantity = out_res.out_quantity;
  assign res.ask_price = out_res.ask_price;
  assign res.bid_price = out_res.bid_price;
  assign res.tag_echo = out_res.tag_echo;
  assign res.last = out_res.last;
endmodule

`default_nettype wire

### test/limit_order_matcher_tb.sv
// Testbench for the limit order matcher: drives buy, sell, best-ask and unused
// requests, predicts fills, rests, rejects and query answers, and checks every result.
// Depends on lom_pkg, lom_if and the limit_order_matcher RTL.
`timescale 1ns / 100ps
`default_nettype none

module limit_order_matcher_tb;
  import lom_pkg::*;

  localparam int CYCLE_LIMIT = 5000000;

  logic clk = 1'b0;
  logic rst = 1'b1;

  lom_req_if req ();
  lom_res_if res ();

  limit_order_matcher dut (.clk(clk), .rst(rst), .req(req), .res(res));

  always #5 clk = ~clk;

  // predictor state
  entry_t bids [BOOK_DEPTH];
  entry_t asks [BOOK_DEPTH];
  int     n_bids;
  int     n_asks;
  res_t   expected_q [$];

  int  mismatches = 0;
  int  cycles = 0;
  bit  idle_on = 1'b1;
  int  req_gap = 0;
  int  res_gap = 0;

  function automatic res_t mk(logic [1:0] k, logic [7:0] b, logic [7:0] s, logic [7:0] sym,
                              logic [19:0] q, logic [23:0] ap, logic [23:0] bp,
                              logic [19:0] tg);
    res_t r;
    r.kind = k; r.buyer = b; r.seller = s; r.out_symbol = sym; r.out_quantity = q;
    r.ask_price = ap; r.bid_price = bp; r.tag_echo = tg; r.last = 1'b0;
    return r;
  endfunction

  // Apply one request to the books and queue the results it produces.
  task automatic predict_match(req_t r);
    res_t        outs [$];
    logic [19:0] left;
    logic [23:0] best;
    logic [19:0] take;
    bit          found;
    bit          buy;
    int          pos;
    entry_t      e;
    left = r.quantity;
    buy = (r.action == ACT_BUY);
    if (r.action == ACT_QUERY) begin
      found = 0; best = '0;
      for (int i = 0; i < n_asks; i++)
        if (asks[i].symbol == r.symbol && (!found || asks[i].price < best)) begin
          best = asks[i].price; found = 1;
        end
      outs.push_back(mk(KIND_QUERY, '0, '0, r.symbol, '0, best, '0, r.query_tag));
    end else if (r.action inside {ACT_BUY, ACT_SELL} && left != 0) begin
      while (left > 0) begin
        found = 0; pos = 0; best = '0;
        if (buy) begin
          for (int i = 0; i < n_asks; i++)
            if (asks[i].symbol == r.symbol && asks[i].price <= r.price &&
                (!found || asks[i].price < best)) begin
              best = asks[i].price; pos = i; found = 1;
            end
        end else begin
          for (int i = 0; i < n_bids; i++)
            if (bids[i].symbol == r.symbol && bids[i].price >= r.price &&
                (!found || bids[i].price > best)) begin
              best = bids[i].price; pos = i; found = 1;
            end
        end
        if (!found) break;
        e = buy ? asks[pos] : bids[pos];
        take = (left < e.qty) ? left : e.qty;
        if (buy)
          outs.push_back(mk(KIND_FILL, r.broker, e.broker, r.symbol, take, e.price,
                            r.price, '0));
        else
          outs.push_back(mk(KIND_FILL, e.broker, r.broker, r.symbol, take, r.price,
                            e.price, '0));
        left -= take;
        if (take == e.qty) begin
          if (buy) begin
            for (int j = pos; j < n_asks - 1; j++) asks[j] = asks[j + 1];
            n_asks--;
          end else begin
            for (int j = pos; j < n_bids - 1; j++) bids[j] = bids[j + 1];
            n_bids--;
          end
        end else if (buy) asks[pos].qty -= take;
        else bids[pos].qty -= take;
      end
      if (left > 0) begin
        e.symbol = r.symbol; e.broker = r.broker; e.qty = left; e.price = r.price;
        if (buy) begin
          if (n_bids < BOOK_DEPTH) begin
            bids[n_bids] = e; n_bids++;
            outs.push_back(mk(KIND_REST, r.broker, '0, r.symbol, left, '0, r.price, '0));
          end else
            outs.push_back(mk(KIND_REJECT, r.broker, '0, r.symbol, left, '0, r.price, '0));
        end else begin
          if (n_asks < BOOK_DEPTH) begin
            asks[n_asks] = e; n_asks++;
            outs.push_back(mk(KIND_REST, '0, r.broker, r.symbol, left, r.price, '0, '0));
          end else
            outs.push_back(mk(KIND_REJECT, '0, r.broker, r.symbol, left, r.price, '0, '0));
        end
      end
    end
    if (outs.size() > 0) outs[outs.size() - 1].last = 1'b1;
    foreach (outs[i]) expected_q.push_back(outs[i]);
  endtask

  // Send one request; prediction happens at the accepting edge.
  task automatic send_order(logic [1:0] act, logic [7:0] sym, logic [19:0] qty,
                            logic [23:0] prc, logic [7:0] brk, logic [19:0] tag);
    req_t r;
    r.action = act; r.symbol = sym; r.quantity = qty; r.price = prc;
    r.broker = brk; r.query_tag = tag;
    if (idle_on && req_gap > 0) begin
      req.valid <= 1'b0;
      while (req_gap > 0) begin
        req_gap--;
        @(posedge clk);
      end
    end
    req.valid    <= 1'b1;
    req.action   <= act;
    req.symbol   <= sym;
    req.quantity <= qty;
    req.price    <= prc;
    req.broker   <= brk;
    req.query_tag <= tag;
    do @(posedge clk); while (!req.ready);
    predict_match(r);
    if (idle_on && $urandom_range(0, 3) == 0) req_gap = $urandom_range(1, 7);
  endtask

  // Result side: random stall bursts and in-order comparison.
  always @(posedge clk) begin
    res_t exp_r;
    if (!rst) begin
      if (res.valid && res.ready) begin
        if (expected_q.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected result kind=%0d", res.kind);
        end else begin
          exp_r = expected_q.pop_front();
          if (exp_r.kind !== res.kind || exp_r.buyer !== res.buyer ||
              exp_r.seller !== res.seller || exp_r.out_symbol !== res.out_symbol ||
              exp_r.out_quantity !== res.out_quantity ||
              exp_r.ask_price !== res.ask_price || exp_r.bid_price !== res.bid_price ||
              exp_r.tag_echo !== res.tag_echo || exp_r.last !== res.last) begin
            mismatches++;
            if (mismatches <= 10)
              $display("mismatch exp k%0d b%0d s%0d y%0d q%0d a%0d p%0d t%0d l%0d",
                       exp_r.kind, exp_r.buyer, exp_r.seller, exp_r.out_symbol,
                       exp_r.out_quantity, exp_r.ask_price, exp_r.bid_price,
                       exp_r.tag_echo, exp_r.last,
                       " / got k%0d b%0d s%0d y%0d q%0d a%0d p%0d t%0d l%0d",
                       res.kind, res.buyer, res.seller,
                       res.out_symbol, res.out_quantity, res.ask_price, res.bid_price,
                       res.tag_echo, res.last);
          end
        end
      end
      if (res_gap > 0) begin
        res_gap--;
        res.ready <= (res_gap == 0);
      end else if (idle_on && $urandom_range(0, 5) == 0) begin
        res_gap = $urandom_range(1, 7);
        res.ready <= 1'b0;
      end else
        res.ready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  task automatic test_extremes();
    send_order(ACT_QUERY, 8'd0, 20'd0, 24'd0, 8'd0, 20'd0);
    send_order(ACT_SELL, 8'hFF, 20'hFFFFF, 24'hFFFFFF, 8'hFF, 20'hFFFFF);
    send_order(ACT_QUERY, 8'hFF, 20'hFFFFF, 24'hFFFFFF, 8'hFF, 20'hFFFFF);
    send_order(ACT_BUY, 8'hFF, 20'd1, 24'hFFFFFF, 8'h00, 20'h0);
    send_order(ACT_BUY, 8'hFF, 20'hFFFFF, 24'hFFFFFF, 8'hA5, 20'h0);
    send_order(ACT_BUY, 8'd3, 20'd0, 24'd50, 8'd1, 20'd0);        // zero quantity
    send_order(ACT_UNUSED, 8'd3, 20'd10, 24'd50, 8'd1, 20'd7);    // unused action
    send_order(ACT_BUY, 8'd0, 20'd5, 24'd0, 8'd2, 20'd0);         // zero price bid
    send_order(ACT_SELL, 8'd0, 20'd3, 24'd0, 8'd3, 20'd0);
    send_order(ACT_SELL, 8'd0, 20'd9, 24'd0, 8'd4, 20'd0);
  endtask

  task automatic test_sweep_and_ties();
    send_order(ACT_SELL, 8'd7, 20'd10, 24'd100, 8'd10, '0);
    send_order(ACT_SELL, 8'd7, 20'd10, 24'd90, 8'd11, '0);
    send_order(ACT_SELL, 8'd7, 20'd10, 24'd90, 8'd12, '0);
    send_order(ACT_SELL, 8'd8, 20'd10, 24'd80, 8'd13, '0);
    send_order(ACT_QUERY, 8'd7, '0, 24'd1, '0, 20'd123);
    send_order(ACT_BUY, 8'd7, 20'd25, 24'd100, 8'd20, '0);
    send_order(ACT_BUY, 8'd7, 20'd20, 24'd95, 8'd21, '0);
    send_order(ACT_SELL, 8'd7, 20'd30, 24'd1, 8'd22, '0);
  endtask

  task automatic test_full_book();
    for (int i = 0; i < BOOK_DEPTH + 2; i++)
      send_order(ACT_SELL, 8'd40, 20'd1, 24'(1000 + i), i[7:0], '0);
    send_order(ACT_BUY, 8'd40, 20'd5, 24'd1002, 8'd99, '0);
    send_order(ACT_BUY, 8'd40, 20'd40, 24'hFFFFFF, 8'd98, '0);
  endtask

  task automatic test_random(int n);
    logic [1:0]  act;
    logic [19:0] qty;
    int r;
    for (int i = 0; i < n; i++) begin
      if (i > n * 4 / 5) idle_on = 1'b0;
      r = $urandom_range(0, 99);
      act = (r < 45) ? ACT_BUY : (r < 90) ? ACT_SELL : (r < 98) ? ACT_QUERY : ACT_UNUSED;
      r = $urandom_range(0, 19);
      qty = (r == 0) ? 20'($urandom) : (r == 1) ? 20'd0 : 20'($urandom_range(1, 60));
      if ($urandom_range(0, 9) == 0)
        send_order(act, 8'($urandom), qty, 24'($urandom), 8'($urandom), 20'($urandom));
      else
        send_order(act, 8'($urandom_range(0, 3)), qty, 24'($urandom_range(95, 105)),
                   8'($urandom), 20'($urandom));
    end
  endtask

  initial begin
    n_bids = 0;
    n_asks = 0;
    req.valid = 1'b0;
    req.action = ACT_BUY; req.symbol = '0; req.quantity = '0;
    req.price = '0; req.broker = '0; req.query_tag = '0;
    res.ready = 1'b0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_extremes();
    test_sweep_and_ties();
    test_full_book();
    test_random(366);
    req.valid <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk);
    repeat (200) @(posedge clk);
    if (mismatches == 0 && expected_q.size() == 0) $display("tb: success");
    else $display("tb: failure");
    $finish;
  end

endmodule

`default_nettype wire

### files.f
hdl/lom_pkg.sv
hdl/lom_if.sv
hdl/lom_front.sv
hdl/lom_engine.sv
hdl/limit_order_matcher.sv
test/limit_order_matcher_tb.sv
